>>> design/cab_pkg.sv
// ============================================================================
// cab_pkg: shared types and constants for the coverage alpha blend block
// Beat structs for both channels, fixed-point constants of the blend math
// and the widths of the per-channel divider.
// ============================================================================
`default_nettype none

package cab_pkg;

    // field widths
    localparam int COORD_W        = 12;
    localparam int CH_W           = 8;
    localparam int SRC_W          = 32;
    localparam int COORD_BITS_DEF = 12;

    // Q1.16 fractions: 65536 is one
    localparam int          FRAC_W = 17;
    localparam logic [16:0] Q_ONE  = 17'h10000;
    localparam logic [16:0] Q_HALF = 17'h08000;

    // sa = (p*65536 + 32512) / 65025 = p + (p*511 + 32512) / 65025
    localparam int SA_DIV      = 65025;
    localparam int SA_EXTRA    = 511;
    localparam int SA_BIAS     = 32512;
    localparam int SA_RECIP    = 66051;     // floor(2^32 / 65025)
    localparam int SA_RECIP_SH = 32;
    localparam int SA_T_W      = 25;        // width of p*511 + 32512
    localparam int SA_Q_W      = 9;         // (p*511 + 32512) / 65025 <= 511
    localparam int SA_PROD_W   = SA_T_W + 17;

    // da = dal*257 + (dal >= 128)
    localparam int DA_MUL = 257;

    // channel divider: quotient of (2*num + oa) / (2*oa), at most 255
    localparam int OA_W       = 18;
    localparam int PROD_W     = 25;
    localparam int DIV_NUM_W  = 27;
    localparam int DIV_DEN_W  = 19;
    localparam int QUO_W      = 9;
    localparam int CH_MAX     = 255;

    typedef struct packed {
        logic [COORD_W-1:0] in_x;
        logic [COORD_W-1:0] in_y;
        logic [CH_W-1:0]    dest_red;
        logic [CH_W-1:0]    dest_green;
        logic [CH_W-1:0]    dest_blue;
        logic [CH_W-1:0]    dest_alpha;
        logic [CH_W-1:0]    coverage;
    } t_in_beat;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CH_W-1:0]    out_red;
        logic [CH_W-1:0]    out_green;
        logic [CH_W-1:0]    out_blue;
        logic [CH_W-1:0]    out_alpha;
        logic               updated;
    } t_out_beat;

endpackage

`default_nettype wire

>>> design/cab_divider.sv
// ============================================================================
// cab_divider: pipelined restoring divider for one color channel
// One quotient bit per register stage, MSB first; the numerator must be
// below den * 2^QUO_W. All stages advance together on i_en.
// ============================================================================
`default_nettype none

module cab_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [cab_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [cab_pkg::DIV_DEN_W-1:0] i_den,
    output logic      [cab_pkg::QUO_W-1:0]     o_quo
);

    localparam int NW = cab_pkg::DIV_NUM_W;
    localparam int DW = cab_pkg::DIV_DEN_W;
    localparam int QW = cab_pkg::QUO_W;

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [NW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [NW-1:0] w_dsh;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        // divisor aligned to the quotient bit of this stage
        assign w_dsh = NW'(w_den_in) << (QW - 1 - j);
        assign w_ge  = (w_rem_in >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= {w_quo_in[QW-2:0], w_ge};
            end
        end

        if (j < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? (w_rem_in - w_dsh) : w_rem_in;
                    r_den[j] <= w_den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

>>> design/coverage_alpha_blend_over_core.sv
// ============================================================================
// coverage_alpha_blend_over_core: source-over blend of a fixed color
// Blends the configured straight-alpha source color over one RGBA8 pixel per
// beat, weighted by an 8-bit coverage, in unsigned Q1.16 fixed point.
// ============================================================================
// One pixel beat is accepted every clock while o_in_ready is high, and one
// result beat leaves per pixel, in order. The pipeline is built of 7 stages
// of alpha math (coverage times color alpha scaled by 1/255^2 through a
// reciprocal multiply, destination weight, output alpha, per-channel
// products and sums), 9 stages of a one-bit-per-stage divider that forms
// each channel's (2*num + oa) / (2*oa), and one output register. A skid
// register behind the output takes a result the sink does not accept, so
// the pipeline keeps taking pixels for that cycle; o_in_ready drops only
// while the skid register is full. When the source alpha comes out zero,
// the pixel leaves unchanged with updated clear.
// The source color register is written over its own valid/ready channel
// (always ready) and must only be written while no pixel is in flight.
// Coordinates are masked to COORD_BITS bits and only those bits are stored.
// ============================================================================
`default_nettype none

module coverage_alpha_blend_over_core #(
    parameter int COORD_BITS = cab_pkg::COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    // source color register
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [cab_pkg::SRC_W-1:0] i_cfg_data,

    // pixel in
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire cab_pkg::t_in_beat         i_in_beat,

    // pixel out
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output cab_pkg::t_out_beat             o_out_beat
);

    localparam int CW  = (COORD_BITS < cab_pkg::COORD_W) ? COORD_BITS : cab_pkg::COORD_W;
    localparam int NST = 17;                  // register stages, output included
    localparam int NCH = 3;                   // red, green, blue
    localparam int FW  = cab_pkg::FRAC_W;
    localparam int TW  = cab_pkg::SA_T_W;
    localparam int QSW = cab_pkg::SA_Q_W;
    localparam int MW  = cab_pkg::SA_PROD_W;
    localparam int OW  = cab_pkg::OA_W;
    localparam int PW  = cab_pkg::PROD_W;
    localparam int NW  = cab_pkg::DIV_NUM_W;
    localparam int DW  = cab_pkg::DIV_DEN_W;
    localparam int QW  = cab_pkg::QUO_W;
    localparam int DWP = 2 * FW;              // width of da*(1-sa) + half
    localparam int AW  = 26;                  // width of oa*255 + half
    localparam int CHW = cab_pkg::CH_W;

    // fields carried along the pipe
    typedef struct packed {
        logic [CW-1:0]  x;
        logic [CW-1:0]  y;
        logic [CHW-1:0] dr;
        logic [CHW-1:0] dg;
        logic [CHW-1:0] db;
        logic [CHW-1:0] dal;
        logic [CHW-1:0] oal;   // from stage 6 on
        logic           upd;   // from stage 5 on
    } t_side;

    // ------------------------------------------------------------------
    // source color register
    // ------------------------------------------------------------------
    logic [cab_pkg::SRC_W-1:0] r_src;
    logic [CHW-1:0]            w_src_ch [NCH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_src <= i_cfg_data;
        end
    end

    assign w_src_ch[0] = r_src[31:24];
    assign w_src_ch[1] = r_src[23:16];
    assign w_src_ch[2] = r_src[15:8];

    // ------------------------------------------------------------------
    // flow control: the whole pipe moves unless the skid register holds
    // a beat the sink has not taken yet
    // ------------------------------------------------------------------
    logic                r_vld [NST];
    logic                w_en;
    logic                r_skid_vld;
    cab_pkg::t_out_beat  r_skid_beat;
    cab_pkg::t_out_beat  r_out_beat;

    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld[0] <= i_in_valid;
                for (int k = 1; k < NST; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (r_skid_vld) begin
                if (i_out_ready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[NST-1] && !i_out_ready) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // skid takes the output beat that the sink left standing
    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && r_vld[NST-1] && !i_out_ready) begin
            r_skid_beat <= r_out_beat;
        end
    end

    assign o_out_valid = r_skid_vld || r_vld[NST-1];
    assign o_out_beat  = r_skid_vld ? r_skid_beat : r_out_beat;

    // ------------------------------------------------------------------
    // side fields
    // ------------------------------------------------------------------
    t_side r_side [NST-1];
    t_side n_side [NST-1];

    // ------------------------------------------------------------------
    // arithmetic stage registers
    // ------------------------------------------------------------------
    logic [15:0]     r0_p,  n0_p;      // coverage * color alpha
    logic [FW-1:0]   r0_da, n0_da;     // destination alpha, Q1.16
    logic [TW-1:0]   r1_t,  n1_t;      // p*511 + 32512
    logic [QSW-1:0]  r1_q,  n1_q;      // quotient estimate of t / 65025
    logic [MW-1:0]   n1_m;
    logic [15:0]     r1_p;
    logic [FW-1:0]   r1_da;
    logic [FW-1:0]   r2_rem, n2_rem;   // t - q*65025, below 2*65025
    logic [QSW-1:0]  r2_q;
    logic [15:0]     r2_p;
    logic [FW-1:0]   r2_da;
    logic [FW-1:0]   r3_sa, n3_sa;     // source alpha, Q1.16
    logic [FW-1:0]   r3_da;
    logic [DWP-1:0]  n4_prod;
    logic [FW-1:0]   r4_sa, r4_dw, n4_dw;
    logic [OW-1:0]   r5_oa, n5_oa;
    logic [PW-1:0]   r5_ps [NCH];
    logic [PW-1:0]   r5_pd [NCH];
    logic [NW-1:0]   r6_num [NCH];
    logic [DW-1:0]   r6_den;
    logic [AW-1:0]   n6_oal_full;
    logic [CHW-1:0]  n6_oal;
    logic [QW-1:0]   w_quo [NCH];
    logic [CHW-1:0]  w_ch [NCH];
    logic [CHW-1:0]  w_dst_ch [NCH];

    // stage 0: coverage times color alpha, destination alpha to Q1.16
    assign n0_p  = 16'(i_in_beat.coverage) * 16'(r_src[7:0]);
    assign n0_da = FW'(i_in_beat.dest_alpha) * FW'(cab_pkg::DA_MUL)
                 + FW'(i_in_beat.dest_alpha[CHW-1]);

    // stage 1: scale by 1/255^2 through reciprocal multiply
    assign n1_t = TW'(r0_p) * TW'(cab_pkg::SA_EXTRA) + TW'(cab_pkg::SA_BIAS);
    assign n1_m = MW'(n1_t) * MW'(cab_pkg::SA_RECIP);
    assign n1_q = QSW'(n1_m >> cab_pkg::SA_RECIP_SH);

    // stage 2: remainder; estimate is low by at most one
    assign n2_rem = FW'(r1_t - TW'(r1_q) * TW'(cab_pkg::SA_DIV));

    // stage 3: sa = p + q, corrected
    assign n3_sa = FW'(r2_p) + FW'(r2_q) + FW'(r2_rem >= FW'(cab_pkg::SA_DIV));

    // stage 4: dw = da * (1 - sa), rounded
    assign n4_prod = DWP'(r3_da) * DWP'(cab_pkg::Q_ONE - r3_sa) + DWP'(cab_pkg::Q_HALF);
    assign n4_dw   = FW'(n4_prod >> 16);

    // stage 5: output alpha and channel products
    assign n5_oa       = OW'(r4_sa) + OW'(r4_dw);
    assign w_dst_ch[0] = r_side[4].dr;
    assign w_dst_ch[1] = r_side[4].dg;
    assign w_dst_ch[2] = r_side[4].db;

    // stage 6: divider operands and alpha out
    assign n6_oal_full = AW'(r5_oa) * AW'(cab_pkg::CH_MAX) + AW'(cab_pkg::Q_HALF);
    assign n6_oal      = ((n6_oal_full >> 16) > AW'(cab_pkg::CH_MAX))
                       ? CHW'(cab_pkg::CH_MAX) : CHW'(n6_oal_full >> 16);

    always_comb begin
        n_side[0].x   = CW'(i_in_beat.in_x);
        n_side[0].y   = CW'(i_in_beat.in_y);
        n_side[0].dr  = i_in_beat.dest_red;
        n_side[0].dg  = i_in_beat.dest_green;
        n_side[0].db  = i_in_beat.dest_blue;
        n_side[0].dal = i_in_beat.dest_alpha;
        n_side[0].oal = '0;
        n_side[0].upd = 1'b0;
        for (int k = 1; k < NST - 1; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[5].upd = (r4_sa != '0);
        n_side[6].upd = r_side[5].upd && (r5_oa != '0);
        n_side[6].oal = n6_oal;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NST - 1; k++) begin
                r_side[k] <= n_side[k];
            end
            r0_p   <= n0_p;
            r0_da  <= n0_da;
            r1_t   <= n1_t;
            r1_q   <= n1_q;
            r1_p   <= r0_p;
            r1_da  <= r0_da;
            r2_rem <= n2_rem;
            r2_q   <= r1_q;
            r2_p   <= r1_p;
            r2_da  <= r1_da;
            r3_sa  <= n3_sa;
            r3_da  <= r2_da;
            r4_sa  <= r3_sa;
            r4_dw  <= n4_dw;
            r5_oa  <= n5_oa;
            for (int c = 0; c < NCH; c++) begin
                r5_ps[c]  <= PW'(w_src_ch[c]) * PW'(r4_sa);
                r5_pd[c]  <= PW'(w_dst_ch[c]) * PW'(r4_dw);
                r6_num[c] <= ((NW'(r5_ps[c]) + NW'(r5_pd[c])) << 1) + NW'(r5_oa);
            end
            r6_den <= DW'(r5_oa) << 1;
        end
    end

    // stages 7..15: one divider per channel
    for (genvar c = 0; c < NCH; c++) begin : g_ch
        cab_divider u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r6_num[c]),
            .i_den (r6_den),
            .o_quo (w_quo[c])
        );
        assign w_ch[c] = (w_quo[c] > QW'(cab_pkg::CH_MAX))
                       ? CHW'(cab_pkg::CH_MAX) : CHW'(w_quo[c]);
    end

    // stage 16: output register, blended or passed through
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_beat.out_x   <= cab_pkg::COORD_W'(r_side[NST-2].x);
            r_out_beat.out_y   <= cab_pkg::COORD_W'(r_side[NST-2].y);
            r_out_beat.updated <= r_side[NST-2].upd;
            if (r_side[NST-2].upd) begin
                r_out_beat.out_red   <= w_ch[0];
                r_out_beat.out_green <= w_ch[1];
                r_out_beat.out_blue  <= w_ch[2];
                r_out_beat.out_alpha <= r_side[NST-2].oal;
            end else begin
                r_out_beat.out_red   <= r_side[NST-2].dr;
                r_out_beat.out_green <= r_side[NST-2].dg;
                r_out_beat.out_blue  <= r_side[NST-2].db;
                r_out_beat.out_alpha <= r_side[NST-2].dal;
            end
        end
    end

`ifndef SYNTHESIS
    // reciprocal estimate may only be short by one divisor
    a_sa_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r2_rem < FW'(2 * cab_pkg::SA_DIV)))
        else $error("sa remainder out of range");

    // source-over alpha never exceeds one
    a_oa_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r5_oa <= OW'(cab_pkg::Q_ONE)))
        else $error("output alpha above one");

    // a blended channel fits in eight bits before clamping
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-2] && r_side[NST-2].upd)
            |-> !(w_quo[0][QW-1] || w_quo[1][QW-1] || w_quo[2][QW-1]))
        else $error("channel quotient above 255");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for coverage_alpha_blend_over_core
// Streams destination pixels through the blend core under random source
// flow gaps and sink back-pressure. Each accepted pixel gets its blended
// result predicted in Q1.16 fixed point, and result beats are checked in
// order. The source color register is swept across extreme and random values.
// ============================================================================

// Expected-result ledger: holds the current source color and a FIFO of
// predicted result beats, one per accepted pixel.
class pixel_ledger;
    logic [31:0]        color = '0;
    cab_pkg::t_out_beat pending_pixels[$];
    int                 mismatches = 0;

    // (2*num + oa) / (2*oa): rounds half up, then saturates at 255
    function logic [7:0] mix(logic [63:0] s, logic [63:0] d, logic [63:0] sa,
                             logic [63:0] dw, logic [63:0] oa);
        logic [63:0] q;
        q = (64'd2 * (s * sa + d * dw) + oa) / (64'd2 * oa);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function cab_pkg::t_out_beat blend_over(cab_pkg::t_in_beat p);
        cab_pkg::t_out_beat r;
        logic [63:0]        sa;
        logic [63:0]        da;
        logic [63:0]        dw;
        logic [63:0]        oa;
        logic [63:0]        oal;
        // coordinates are already COORD_BITS wide at the default parameter
        r.out_x     = p.in_x;
        r.out_y     = p.in_y;
        r.out_red   = p.dest_red;
        r.out_green = p.dest_green;
        r.out_blue  = p.dest_blue;
        r.out_alpha = p.dest_alpha;
        r.updated   = 1'b0;
        sa = (64'(p.coverage) * 64'(color[7:0]) * 64'd65536 + 64'd32512) / 64'd65025;
        if (sa != 0) begin
            da = (64'(p.dest_alpha) * 64'd65536 + 64'd127) / 64'd255;
            dw = (da * (64'd65536 - sa) + 64'd32768) >> 16;
            oa = sa + dw;
            if (oa != 0) begin
                r.out_red   = mix(64'(color[31:24]), 64'(p.dest_red), sa, dw, oa);
                r.out_green = mix(64'(color[23:16]), 64'(p.dest_green), sa, dw, oa);
                r.out_blue  = mix(64'(color[15:8]), 64'(p.dest_blue), sa, dw, oa);
                oal = (oa * 64'd255 + 64'd32768) >> 16;
                r.out_alpha = (oal > 64'd255) ? 8'd255 : oal[7:0];
                r.updated   = 1'b1;
            end
        end
        return r;
    endfunction

    function void note_pixel(cab_pkg::t_in_beat p);
        pending_pixels.push_back(blend_over(p));
    endfunction

    function void check_pixel(cab_pkg::t_out_beat got);
        cab_pkg::t_out_beat want;
        if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing pending: %h", $time, got);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_red !== want.out_red || got.out_green !== want.out_green ||
            got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
            got.updated !== want.updated) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp x=%0d y=%0d rgba=%h_%h_%h_%h upd=%b",
                         $time, want.out_x, want.out_y, want.out_red, want.out_green,
                         want.out_blue, want.out_alpha, want.updated,
                         " | got x=%0d y=%0d rgba=%h_%h_%h_%h upd=%b",
                         got.out_x, got.out_y, got.out_red, got.out_green,
                         got.out_blue, got.out_alpha, got.updated);
        end
    endfunction
endclass

module tb;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [cab_pkg::SRC_W-1:0] i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    cab_pkg::t_in_beat         i_in_beat   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    cab_pkg::t_out_beat        o_out_beat;

    // request from the stimulus side for one long sink hold-off
    bit                        hold_req = 1'b0;

    pixel_ledger               ledger = new;

    coverage_alpha_blend_over_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (about 1400 pixels at a
    // quarter-rate sink with gaps, plus the long sink hold and phase drains).
    initial begin
        #3_000_000;
        $display("FAIL coverage_alpha_blend_over_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pixel and config helpers
    // ------------------------------------------------------------------------
    function automatic cab_pkg::t_in_beat mk_pixel(logic [11:0] x, logic [11:0] y,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b, logic [7:0] a,
                                                   logic [7:0] cov);
        cab_pkg::t_in_beat p;
        p.in_x       = x;
        p.in_y       = y;
        p.dest_red   = r;
        p.dest_green = g;
        p.dest_blue  = b;
        p.dest_alpha = a;
        p.coverage   = cov;
        return p;
    endfunction

    // Biased toward the alpha extremes: zero coverage and zero / full alpha
    // hit the pass-through and full-replace corners often.
    function automatic logic [7:0] alpha_pick();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cab_pkg::t_in_beat rand_pixel();
        cab_pkg::t_in_beat p;
        p = cab_pkg::t_in_beat'($urandom());
        p.in_x       = ($urandom_range(0, 15) == 0) ? 12'hFFF : 12'($urandom());
        p.in_y       = ($urandom_range(0, 15) == 0) ? 12'h000 : 12'($urandom());
        p.dest_red   = 8'($urandom());
        p.dest_green = 8'($urandom());
        p.dest_blue  = 8'($urandom());
        p.dest_alpha = alpha_pick();
        p.coverage   = alpha_pick();
        return p;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic push_pixel(input cab_pkg::t_in_beat p);
        i_in_valid <= 1'b1;
        i_in_beat  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_pixel(p);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop valid, let every pending result drain, then keep idling (pipeline is
    // 17 deep) so the color register only changes while idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [31:0] c);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.color = c;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sink: ready pattern changes at random intervals between always
    // ready, half, quarter and mostly ready. A hold request parks ready low
    // far longer than the pipe plus skid can absorb.
    // ------------------------------------------------------------------------
    initial begin : sink
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_out_ready <= 1'b0;
                    repeat (300) @(posedge i_clk);
                end
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Result monitor: values sampled here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            ledger.check_pixel(o_out_beat);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] c;
        int          burst_left;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset color has zero alpha: every pixel must pass through untouched.
        push_pixel(mk_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        push_pixel(mk_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(mk_pixel(12'd17, 12'd300, 8'h5A, 8'hA5, 8'h3C, 8'd200, 8'd200));
        settle();

        // Opaque color: full replace, transparent dest, zero coverage,
        // tiny coverage over empty and over opaque dest, coordinate corners.
        write_color(32'hFF00_80FF);
        push_pixel(mk_pixel(12'd1, 12'd2, 8'h00, 8'h00, 8'h00, 8'd255, 8'd255));
        push_pixel(mk_pixel(12'd3, 12'd4, 8'h12, 8'h34, 8'h56, 8'd0, 8'd255));
        push_pixel(mk_pixel(12'd5, 12'd6, 8'h9A, 8'hBC, 8'hDE, 8'd99, 8'd0));
        push_pixel(mk_pixel(12'd7, 12'd8, 8'h80, 8'h80, 8'h80, 8'd128, 8'd128));
        push_pixel(mk_pixel(12'd9, 12'd10, 8'hFF, 8'h00, 8'hFF, 8'd0, 8'd1));
        push_pixel(mk_pixel(12'd11, 12'd12, 8'h00, 8'hFF, 8'h00, 8'd255, 8'd1));
        push_pixel(mk_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(mk_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'd200, 8'd64));
        settle();

        // Faintest nonzero source alpha (color alpha 1).
        write_color(32'h00FF_0001);
        push_pixel(mk_pixel(12'h800, 12'h001, 8'h40, 8'h40, 8'h40, 8'd0, 8'd1));
        push_pixel(mk_pixel(12'h7FF, 12'h002, 8'hC0, 8'h10, 8'hEE, 8'd0, 8'd255));
        push_pixel(mk_pixel(12'h555, 12'hAAA, 8'hC0, 8'h10, 8'hEE, 8'd255, 8'd255));
        push_pixel(mk_pixel(12'hAAA, 12'h555, 8'h01, 8'hFE, 8'h77, 8'd77, 8'd0));
        settle();

        write_color(32'h3CC3_A580);
        push_pixel(mk_pixel(12'h123, 12'hEDC, 8'hF0, 8'h0F, 8'h99, 8'd128, 8'd200));

        // Random phases, 150 pixels each under a fresh color. Phase 4 runs
        // back-to-back and asks the sink for a long hold so the skid fills
        // and input ready drops; phase 5 is back-to-back with normal sink.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:       c = 32'hFFFF_FFFF;
                1:       c = 32'h0000_0000;
                2:       c = 32'h0000_00FF;
                3:       c = 32'hFFFF_FF01;
                default: c = $urandom();
            endcase
            settle();
            write_color(c);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < 150; n++) begin
                if (ph == 4 && n == 20)
                    hold_req = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if (ph != 4 && ph != 5)
                        idle_input($urandom_range(0, 6));
                end
                burst_left--;
                push_pixel(rand_pixel());
            end
        end
        settle();

        if (ledger.mismatches == 0)
            $display("PASS coverage_alpha_blend_over_core");
        else
            $display("FAIL coverage_alpha_blend_over_core");
        $finish;
    end

endmodule
